/* rtl/rqvs_pkg.sv */
// ============================================================================
// rqvs_pkg
// Shared types, widths and the sine table builder for the rotated quad
// vertex setup unit.
// ============================================================================
package rqvs_pkg;

    // Angle resolution and quarter-wave table size
    localparam int ANGLE_BITS = 16;
    localparam int SINE_DEPTH = 1024;
    localparam int QSHIFT     = ANGLE_BITS - 2;
    localparam int IDX_W      = $clog2(SINE_DEPTH + 1);

    // Fixed-point widths
    localparam int SIN_MAG_W  = 17;                 // Q1.16 magnitude, up to 1.0
    localparam int TRIG_W     = SIN_MAG_W + 1;      // signed sine / cosine
    localparam int DIM_W      = 24;                 // half dimension, signed Q.9
    localparam int PROD_W     = DIM_W + TRIG_W;     // Q.25 product
    localparam int SUM_W      = 44;                 // Q.25 corner sum
    localparam int POS_W      = 24;
    localparam int TEX_W      = 16;
    localparam int RGBA_W     = 32;

    // Stream widths
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 120;

    // Corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    // Table generation constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef logic [SIN_MAG_W-1:0] sine_rom_t [SINE_DEPTH + 1];

    // One sprite; last member sits in the lowest bits of tdata
    typedef struct packed {
        logic [15:0]        angle;
        logic [RGBA_W-1:0]  rgba;
        logic [TEX_W-1:0]   uv_h;
        logic [TEX_W-1:0]   uv_w;
        logic [TEX_W-1:0]   uv_y;
        logic [TEX_W-1:0]   uv_x;
        logic [22:0]        dest_h;
        logic [22:0]        dest_w;
        logic signed [23:0] dest_y;
        logic signed [23:0] dest_x;
    } sprite_t;

    // Per-sprite terms shared by all six vertices
    typedef struct packed {
        logic signed [PROD_W-1:0] hw_cos;
        logic signed [PROD_W-1:0] hh_sin;
        logic signed [PROD_W-1:0] hw_sin;
        logic signed [PROD_W-1:0] hh_cos;
        logic signed [SUM_W-1:0]  base_x;
        logic signed [SUM_W-1:0]  base_y;
        logic [TEX_W-1:0]         u_lo;
        logic [TEX_W-1:0]         u_hi;
        logic [TEX_W-1:0]         v_lo;
        logic [TEX_W-1:0]         v_hi;
        logic [RGBA_W-1:0]        rgba;
    } quad_terms_t;

    // Quarter-wave sine, Q1.16, Taylor series to x^13 in Q30
    function automatic sine_rom_t sine_build();
        sine_rom_t   tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        begin
            for (int k = 0; k <= SINE_DEPTH; k++)
            begin
                x    = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 6; n++)
                begin
                    term = (term * x2) >> 30;
                    term = term / TAYLOR_DIV[n-1];
                    if (n % 2 == 1)
                        sum = sum - longint'(term);
                    else
                        sum = sum + longint'(term);
                end
                if (sum < 0)
                    sum = 0;
                tbl[k] = SIN_MAG_W'((64'(sum) + 64'd8192) >> 14);
            end
            tbl[0]          = '0;
            tbl[SINE_DEPTH] = SIN_MAG_W'(65536);
            return tbl;
        end
    endfunction

endpackage

/* rtl/rotated_quad_vertex_setup_unit.sv */
// ============================================================================
// rotated_quad_vertex_setup_unit
// Rotated sprite quad setup: six triangle vertices per sprite.
// ============================================================================
// Path to the first vertex: input register, sine ROM read, product
//   register, then the vertex output register.
// Output: six vertices on consecutive cycles while m_axis_tready is high,
//   paced by the single vertex output register; the next sprite is taken in
//   while the current one is still being emitted.
// Reset clears the valid flags and the vertex counter; the sine ROM is fixed.
// ============================================================================
module rotated_quad_vertex_setup_unit
    import rqvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // dest_x, dest_y, dest_w, dest_h, uv_x, uv_y, uv_w, uv_h, rgba, angle
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // pos_x, pos_y, tex_u, tex_v, rgba_out, corner
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic        a_valid_reg;
    logic        a_valid_next;
    logic        b_valid_reg;
    logic        b_valid_next;
    logic        c_valid_reg;
    logic        c_valid_next;
    sprite_t     a_sprite_reg;
    sprite_t     b_sprite_reg;
    logic        s_accept;
    logic        a_move;
    logic        b_move;
    logic        a_free;
    logic        b_free;
    logic        c_free;
    logic        c_done;
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
    quad_terms_t terms;

    // Stage flow: input reg -> ROM stage -> product stage (held while emitting)
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign c_free        = !c_valid_reg || c_done;
    assign b_move        = b_valid_reg && c_free;
    assign b_free        = !b_valid_reg || b_move;
    assign a_move        = a_valid_reg && b_free;
    assign a_free        = !a_valid_reg || a_move;
    assign s_axis_tready = a_free;

    assign a_valid_next = s_accept || (a_valid_reg && !a_move);
    assign b_valid_next = a_move || (b_valid_reg && !b_move);
    assign c_valid_next = b_move || (c_valid_reg && !c_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Sprite payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
            a_sprite_reg <= s_axis_tdata[$bits(sprite_t)-1:0];
        if (a_move)
            b_sprite_reg <= a_sprite_reg;
    end

    rqvs_trig u_trig (
        .clk     (clk),
        .load    (a_move),
        .angle   (a_sprite_reg.angle),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    rqvs_corner_mult u_corner_mult (
        .clk     (clk),
        .load    (b_move),
        .sprite  (b_sprite_reg),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .terms   (terms)
    );

    rqvs_vertex_emit u_vertex_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .terms_valid   (c_valid_reg),
        .terms         (terms),
        .terms_done    (c_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> a_valid_reg)
        else $error("accepted sprite not held in input register");

    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        a_move |=> b_valid_reg)
        else $error("sprite lost between input and ROM stage");

    a_terms_fill: assert property (@(posedge clk) disable iff (!rst_n)
        b_move |=> c_valid_reg)
        else $error("sprite lost between ROM and product stage");

endmodule

/* rtl/rqvs_trig.sv */
// ============================================================================
// rqvs_trig
// Sine and cosine lookup from the quarter-wave ROM, two read ports with
// registered data; sign applied after the register.
// ============================================================================
module rqvs_trig
    import rqvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  logic [15:0]              angle,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic signed [TRIG_W-1:0] cos_val
);

    localparam sine_rom_t               SINE_ROM = sine_build();
    localparam logic [ANGLE_BITS-1:0]   QUARTER  = ANGLE_BITS'(1) << QSHIFT;
    localparam int                      SCALE_W  = QSHIFT + IDX_W;

    logic [ANGLE_BITS-1:0] ang;
    logic [ANGLE_BITS-1:0] ang_c;
    logic [IDX_W-1:0]      sin_addr;
    logic [IDX_W-1:0]      cos_addr;
    logic [SIN_MAG_W-1:0]  sin_mag_reg;
    logic [SIN_MAG_W-1:0]  cos_mag_reg;
    logic                  sin_neg_reg;
    logic                  cos_neg_reg;
    logic signed [TRIG_W-1:0] sin_ext;
    logic signed [TRIG_W-1:0] cos_ext;

    // Table address: phase scaled to the table, mirrored in odd quadrants
    function automatic logic [IDX_W-1:0] trig_addr(input logic [ANGLE_BITS-1:0] a);
        logic [QSHIFT-1:0]  phase;
        logic [SCALE_W-1:0] scaled;
        logic [IDX_W-1:0]   idx;
        begin
            phase  = a[QSHIFT-1:0];
            scaled = SCALE_W'(phase) * SCALE_W'(SINE_DEPTH);
            idx    = scaled[SCALE_W-1:QSHIFT];
            return a[QSHIFT] ? (IDX_W'(SINE_DEPTH) - idx) : idx;
        end
    endfunction

    // Cosine is the sine a quarter turn on, wrapping
    assign ang      = ANGLE_BITS'(angle);
    assign ang_c    = ang + QUARTER;
    assign sin_addr = trig_addr(ang);
    assign cos_addr = trig_addr(ang_c);

    // ROM read
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sin_mag_reg <= SINE_ROM[sin_addr];
            cos_mag_reg <= SINE_ROM[cos_addr];
            sin_neg_reg <= ang[ANGLE_BITS-1];
            cos_neg_reg <= ang_c[ANGLE_BITS-1];
        end
    end

    // Lower half-turn negates
    assign sin_ext = signed'(TRIG_W'(sin_mag_reg));
    assign cos_ext = signed'(TRIG_W'(cos_mag_reg));
    assign sin_val = sin_neg_reg ? -sin_ext : sin_ext;
    assign cos_val = cos_neg_reg ? -cos_ext : cos_ext;

endmodule

/* rtl/rqvs_corner_mult.sv */
// ============================================================================
// rqvs_corner_mult
// Half-dimension by sine/cosine products, origin terms and saturated texture
// extents, registered once per sprite.
// ============================================================================
module rqvs_corner_mult
    import rqvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  sprite_t                  sprite,
    input  logic signed [TRIG_W-1:0] sin_val,
    input  logic signed [TRIG_W-1:0] cos_val,
    output quad_terms_t              terms
);

    quad_terms_t terms_reg;
    quad_terms_t terms_next;

    logic signed [PROD_W-1:0] hw_ext;
    logic signed [PROD_W-1:0] hh_ext;
    logic signed [PROD_W-1:0] sin_ext;
    logic signed [PROD_W-1:0] cos_ext;
    logic signed [SUM_W-1:0]  x_ext;
    logic signed [SUM_W-1:0]  y_ext;
    logic signed [SUM_W-1:0]  w_ext;
    logic signed [SUM_W-1:0]  h_ext;
    logic [TEX_W:0]           u_sum;
    logic [TEX_W:0]           v_sum;

    // Operand extension (w/2 in Q.9 is the raw Q.8 width)
    assign hw_ext  = PROD_W'(sprite.dest_w);
    assign hh_ext  = PROD_W'(sprite.dest_h);
    assign sin_ext = PROD_W'(sin_val);
    assign cos_ext = PROD_W'(cos_val);
    assign x_ext   = SUM_W'(sprite.dest_x);
    assign y_ext   = SUM_W'(sprite.dest_y);
    assign w_ext   = SUM_W'(sprite.dest_w);
    assign h_ext   = SUM_W'(sprite.dest_h);

    // Texture extents, clamped
    assign u_sum = {1'b0, sprite.uv_x} + {1'b0, sprite.uv_w};
    assign v_sum = {1'b0, sprite.uv_y} + {1'b0, sprite.uv_h};

    always_comb
    begin
        terms_next.hw_cos = hw_ext * cos_ext;
        terms_next.hh_sin = hh_ext * sin_ext;
        terms_next.hw_sin = hw_ext * sin_ext;
        terms_next.hh_cos = hh_ext * cos_ext;
        terms_next.base_x = (x_ext <<< 17) + (w_ext <<< 16);
        terms_next.base_y = (y_ext <<< 17) + (h_ext <<< 16);
        terms_next.u_lo   = sprite.uv_x;
        terms_next.u_hi   = u_sum[TEX_W] ? '1 : u_sum[TEX_W-1:0];
        terms_next.v_lo   = sprite.uv_y;
        terms_next.v_hi   = v_sum[TEX_W] ? '1 : v_sum[TEX_W-1:0];
        terms_next.rgba   = sprite.rgba;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

/* rtl/rqvs_vertex_emit.sv */
// ============================================================================
// rqvs_vertex_emit
// Walks the six vertices of a sprite, forms each corner position with a
// three-term add, round and clamp, and holds the vertex in the output register.
// ============================================================================
module rqvs_vertex_emit
    import rqvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   terms_valid,
    input  quad_terms_t            terms,
    output logic                   terms_done,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam logic [2:0] LAST_CNT = 3'd5;
    localparam int         RND_W    = SUM_W - 17;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(65536);
    localparam logic signed [RND_W-1:0] POS_MAX    = RND_W'(8388607);
    localparam logic signed [RND_W-1:0] POS_MIN    = -RND_W'(8388608);

    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic                   tvalid_reg;
    logic                   tvalid_next;
    logic [OUT_TDATA_W-1:0] tdata_reg;
    logic [OUT_TDATA_W-1:0] tdata_next;
    logic                   tlast_reg;
    logic                   out_load;
    logic [1:0]             corner;
    logic                   cx_pos;
    logic                   cy_pos;
    logic signed [SUM_W-1:0] t_hw_cos;
    logic signed [SUM_W-1:0] t_hh_sin;
    logic signed [SUM_W-1:0] t_hw_sin;
    logic signed [SUM_W-1:0] t_hh_cos;
    logic signed [SUM_W-1:0] rx;
    logic signed [SUM_W-1:0] ry;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;

    // Q.25 to Q15.8: add one half, floor, clamp
    function automatic logic [POS_W-1:0] pos_round(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        begin
            biased = v + ROUND_HALF;
            r      = biased[SUM_W-1:17];
            if (r > POS_MAX)
                return POS_MAX[POS_W-1:0];
            else if (r < POS_MIN)
                return POS_MIN[POS_W-1:0];
            else
                return r[POS_W-1:0];
        end
    endfunction

    // Vertex order: TL, BL, BR, BR, TR, TL
    always_comb
    begin
        case (cnt_reg) inside
            3'd1:       corner = CORNER_BL;
            3'd2, 3'd3: corner = CORNER_BR;
            3'd4:       corner = CORNER_TR;
            default:    corner = CORNER_TL;
        endcase
    end

    assign cx_pos = (corner == CORNER_BR) || (corner == CORNER_TR);
    assign cy_pos = (corner == CORNER_TL) || (corner == CORNER_TR);

    // Corner position
    assign t_hw_cos = SUM_W'(terms.hw_cos);
    assign t_hh_sin = SUM_W'(terms.hh_sin);
    assign t_hw_sin = SUM_W'(terms.hw_sin);
    assign t_hh_cos = SUM_W'(terms.hh_cos);

    assign rx = (cx_pos ? t_hw_cos : -t_hw_cos) + (cy_pos ? -t_hh_sin : t_hh_sin)
              + terms.base_x;
    assign ry = (cx_pos ? t_hw_sin : -t_hw_sin) + (cy_pos ? t_hh_cos : -t_hh_cos)
              + terms.base_y;

    assign pos_x = pos_round(rx);
    assign pos_y = pos_round(ry);
    assign tex_u = cx_pos ? terms.u_hi : terms.u_lo;
    assign tex_v = cy_pos ? terms.v_hi : terms.v_lo;

    assign tdata_next = {6'd0, corner, terms.rgba, tex_v, tex_u, pos_y, pos_x};

    // Output register handshake and vertex count
    assign out_load    = terms_valid && (!tvalid_reg || m_axis_tready);
    assign terms_done  = out_load && (cnt_reg == LAST_CNT);
    assign tvalid_next = out_load || (tvalid_reg && !m_axis_tready);
    assign cnt_next    = terms_done ? 3'd0 : (out_load ? cnt_reg + 3'd1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 3'd0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= (cnt_reg == LAST_CNT);
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

    // Checks
    a_last_is_tl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[113:112] == CORNER_TL)
        else $error("last vertex is not the top-left corner");

    a_held_mid_sprite: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 3'd0 |-> terms_valid)
        else $error("sprite terms released mid-sequence");

    a_last_follows_sixth: assert property (@(posedge clk) disable iff (!rst_n)
        terms_done |=> m_axis_tvalid && m_axis_tlast)
        else $error("sixth vertex not flagged last");

endmodule
